>>> rtl/vfpid_pkg.sv
// Shared types and constants for the velocity-form PID core.
// Used by vfpid_mac, vfpid_ctrl and velocity_form_pid_core. No dependencies.
package vfpid_pkg;

   // History ring
   localparam int HIST_DEPTH = 4;
   localparam int HIST_IDX_W = $clog2(HIST_DEPTH);

   // Field and datapath widths
   localparam int DATA_W   = 16;  // samples, gains, limits, drive
   localparam int DER_W    = 22;  // four-point derivative sum
   localparam int SEC_W    = 20;  // four-point second difference
   localparam int ERR_W    = 17;  // setpoint minus sample
   localparam int MUL_W    = 24;  // shared multiplier operand width
   localparam int PROD_W   = 2 * MUL_W;
   localparam int ACC_W    = 36;  // der + ki*err - kd*sec
   localparam int SPLIT_W  = 18;  // low slice of the inner sum for the kp multiply
   localparam int TOT_W    = 52;  // kp * inner and drive sum
   localparam int QUO_W    = 18;  // derivative sum divided by six

   // Divide by six: floor(x * DIV_RECIP / 2^DIV_SHIFT) is exact for x < 2^21
   localparam int DIV_SHIFT = 24;
   localparam logic signed [MUL_W-1:0] DIV_RECIP = 24'sd2796203;

   // Tap weights, oldest sample first
   localparam logic signed [5:0] DER_WEIGHT [HIST_DEPTH] =
      '{6'sd2, -6'sd9, 6'sd18, -6'sd11};
   localparam logic signed [3:0] SEC_WEIGHT [HIST_DEPTH] =
      '{4'sd2, -4'sd5, 4'sd4, -4'sd1};

   // Control register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SETPOINT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_MIN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_MAX  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_MODE  = 3'd6;

   // Control register reset values
   localparam logic signed [DATA_W-1:0] RST_SETPOINT   = 16'sd100;
   localparam logic signed [DATA_W-1:0] RST_PROP_GAIN  = 16'sd20;
   localparam logic signed [DATA_W-1:0] RST_INTEG_GAIN = 16'sd2;
   localparam logic signed [DATA_W-1:0] RST_DERIV_GAIN = 16'sd2;
   localparam logic signed [DATA_W-1:0] RST_DRIVE_MIN  = -16'sd10000;
   localparam logic signed [DATA_W-1:0] RST_DRIVE_MAX  = 16'sd10000;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TAP,
      ST_DIV,
      ST_IERR,
      ST_DSEC,
      ST_INNER,
      ST_PLO,
      ST_PHI,
      ST_ADD,
      ST_SAT,
      ST_HOLD
   } state_type;

   // Operand pairs for the shared multiplier
   typedef enum logic [2:0] {
      MS_RECIP,
      MS_IERR,
      MS_DSEC,
      MS_PLO,
      MS_PHI
   } mul_sel_type;

   // Sequencer to datapath control
   typedef struct packed {
      logic                  busy;
      logic                  tap_en;
      logic                  tap_first;
      logic [HIST_IDX_W-1:0] tap_k;
      logic                  mul_en;
      mul_sel_type           mul_sel;
      logic                  acc_der;
      logic                  acc_add;
      logic                  acc_sub;
      logic                  tot_lo;
      logic                  tot_hi;
      logic                  sat;
      logic                  hold;
   } ctl_type;

endpackage

>>> rtl/velocity_form_pid_core.sv
// Velocity-form PID core: one process sample in, one saturated drive beat out.
// Samples are taken one at a time: req_stall stays high until the sequencer is back in idle,
// and a drive stall holds it in the saturate or hold step. Automatic mode runs a tap walk over
// each history sample, then 8 steps around 5 shared 24x24 multiplies.
// Reset (synchronous): control registers to defaults, history, slot and drive to zero.
// Depends on vfpid_pkg, vfpid_mac and vfpid_ctrl.
module velocity_form_pid_core
   import vfpid_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   // sample channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [DATA_W-1:0]    req_sample,
   // drive channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [DATA_W-1:0]    rsp_drive,
   // control register writes
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [DATA_W-1:0]           csr_wdata
);

   ctl_type ctl;
   logic    accept;
   logic    out_free;

   // Control registers
   logic signed [DATA_W-1:0] setpoint_ff, prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic signed [DATA_W-1:0] drive_min_ff, drive_max_ff;
   logic                     auto_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff   <= RST_SETPOINT;
         prop_gain_ff  <= RST_PROP_GAIN;
         integ_gain_ff <= RST_INTEG_GAIN;
         deriv_gain_ff <= RST_DERIV_GAIN;
         drive_min_ff  <= RST_DRIVE_MIN;
         drive_max_ff  <= RST_DRIVE_MAX;
         auto_mode_ff  <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SETPOINT:   setpoint_ff   <= signed'(csr_wdata);
            CSR_PROP_GAIN:  prop_gain_ff  <= signed'(csr_wdata);
            CSR_INTEG_GAIN: integ_gain_ff <= signed'(csr_wdata);
            CSR_DERIV_GAIN: deriv_gain_ff <= signed'(csr_wdata);
            CSR_DRIVE_MIN:  drive_min_ff  <= signed'(csr_wdata);
            CSR_DRIVE_MAX:  drive_max_ff  <= signed'(csr_wdata);
            CSR_AUTO_MODE:  auto_mode_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Handshake
   assign req_stall = ctl.busy;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid || !rsp_stall;

   vfpid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .auto_mode (auto_mode_ff),
      .out_free  (out_free),
      .ctl       (ctl)
   );

   // History ring and write slot
   logic signed [DATA_W-1:0] hist_ff [HIST_DEPTH];
   logic [HIST_IDX_W-1:0]    slot_ff;
   logic signed [DATA_W-1:0] sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
         slot_ff <= '0;
      end else if (accept) begin
         hist_ff[slot_ff] <= req_sample;
         slot_ff          <= slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_sample;
      end
   end

   // Tap walk, oldest first: slot_ff already points one past the newest
   logic [HIST_IDX_W-1:0]    tap_idx;
   logic signed [DATA_W-1:0] tap_sample;
   logic signed [DER_W-1:0]  der_term;
   logic signed [SEC_W-1:0]  sec_term;
   logic signed [DER_W-1:0]  der_sum_ff, der_sum_in;
   logic signed [SEC_W-1:0]  sec_sum_ff, sec_sum_in;

   assign tap_idx    = slot_ff + ctl.tap_k;
   assign tap_sample = hist_ff[tap_idx];
   assign der_term   = DER_W'(tap_sample) * DER_W'(DER_WEIGHT[ctl.tap_k]);
   assign sec_term   = SEC_W'(tap_sample) * SEC_W'(SEC_WEIGHT[ctl.tap_k]);

   always_comb begin
      der_sum_in = der_sum_ff;
      sec_sum_in = sec_sum_ff;
      if (ctl.tap_en) begin
         der_sum_in = (ctl.tap_first ? '0 : der_sum_ff) + der_term;
         sec_sum_in = (ctl.tap_first ? '0 : sec_sum_ff) + sec_term;
      end
   end

   always_ff @(posedge clock) begin
      der_sum_ff <= der_sum_in;
      sec_sum_ff <= sec_sum_in;
   end

   // Multiplier operand select
   logic [DER_W-1:0]         der_mag;
   logic signed [ERR_W-1:0]  err;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [MUL_W-1:0]  op_a, op_b;
   logic signed [PROD_W-1:0] prod;

   assign der_mag = der_sum_ff[DER_W-1] ? DER_W'(-der_sum_ff) : DER_W'(der_sum_ff);
   assign err     = ERR_W'(setpoint_ff) - ERR_W'(sample_ff);

   always_comb begin
      unique case (ctl.mul_sel)
         MS_RECIP: begin
            op_a = DIV_RECIP;
            op_b = signed'(MUL_W'(der_mag));
         end
         MS_IERR: begin
            op_a = MUL_W'(integ_gain_ff);
            op_b = MUL_W'(err);
         end
         MS_DSEC: begin
            op_a = MUL_W'(deriv_gain_ff);
            op_b = MUL_W'(sec_sum_ff);
         end
         MS_PLO: begin
            op_a = MUL_W'(prop_gain_ff);
            op_b = signed'(MUL_W'(acc_ff[SPLIT_W-1:0]));
         end
         MS_PHI: begin
            op_a = MUL_W'(prop_gain_ff);
            op_b = MUL_W'(signed'(acc_ff[ACC_W-1:SPLIT_W]));
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   vfpid_mac u_mac (
      .clock  (clock),
      .mul_en (ctl.mul_en),
      .op_a   (op_a),
      .op_b   (op_b),
      .prod   (prod)
   );

   // Inner sum: der/6 (truncated toward zero) + ki*err - kd*sec
   logic [QUO_W-1:0] quo;

   assign quo = prod[DIV_SHIFT +: QUO_W];

   always_comb begin
      acc_in = acc_ff;
      if (ctl.acc_der) begin
         acc_in = der_sum_ff[DER_W-1] ? -ACC_W'(signed'({1'b0, quo}))
                                      : ACC_W'(signed'({1'b0, quo}));
      end else if (ctl.acc_add) begin
         acc_in = acc_ff + prod[ACC_W-1:0];
      end else if (ctl.acc_sub) begin
         acc_in = acc_ff - prod[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // kp * inner assembled from low and high partial products
   logic signed [TOT_W-1:0] tot_ff, tot_in;

   always_comb begin
      tot_in = tot_ff;
      if (ctl.tot_lo) begin
         tot_in = TOT_W'(prod);
      end else if (ctl.tot_hi) begin
         tot_in = tot_ff + {prod[TOT_W-SPLIT_W-1:0], {SPLIT_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      tot_ff <= tot_in;
   end

   // Drive accumulate and saturate; max checked first for inverted limits
   logic signed [DATA_W-1:0] drive_ff, drive_in;
   logic signed [TOT_W-1:0]  drive_sum;

   assign drive_sum = TOT_W'(drive_ff) + tot_ff;

   always_comb begin
      drive_in = drive_ff;
      if (ctl.sat) begin
         priority if (drive_sum > TOT_W'(drive_max_ff)) begin
            drive_in = drive_max_ff;
         end else if (drive_sum < TOT_W'(drive_min_ff)) begin
            drive_in = drive_min_ff;
         end else begin
            drive_in = drive_sum[DATA_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff <= '0;
      end else begin
         drive_ff <= drive_in;
      end
   end

   // Output beat register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_drive_ff, rsp_drive_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_drive_in = rsp_drive_ff;
      if (ctl.sat || ctl.hold) begin
         rsp_valid_in = 1'b1;
         rsp_drive_in = drive_in;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_drive_ff <= rsp_drive_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

endmodule

>>> rtl/vfpid_mac.sv
// Shared signed multiplier with registered product.
// Depends on vfpid_pkg for operand widths.
module vfpid_mac
   import vfpid_pkg::*;
(
   input  logic                     clock,
   input  logic                     mul_en,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   // One multiply per issue; product holds otherwise
   always_comb begin
      prod_in = prod_ff;
      if (mul_en) begin
         prod_in = PROD_W'(op_a) * PROD_W'(op_b);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> rtl/vfpid_ctrl.sv
// Sequencer for the PID core: tap walk, then the multiply steps, then saturate (manual mode: hold).
// Depends on vfpid_pkg for state, select and control types.
module vfpid_ctrl
   import vfpid_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  logic    auto_mode,
   input  logic    out_free,
   output ctl_type ctl
);

   state_type             state_ff;
   state_type             state_in;
   logic [HIST_IDX_W-1:0] tap_k_ff;
   logic [HIST_IDX_W-1:0] tap_k_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_k_ff <= '0;
      end else begin
         state_ff <= state_in;
         tap_k_ff <= tap_k_in;
      end
   end

   // Next state and per-step controls
   always_comb begin
      state_in      = state_ff;
      tap_k_in      = tap_k_ff;
      ctl           = '0;
      ctl.mul_sel   = MS_RECIP;
      ctl.busy      = (state_ff != ST_IDLE);
      ctl.tap_k     = tap_k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               tap_k_in = '0;
               state_in = auto_mode ? ST_TAP : ST_HOLD;
            end
         end
         ST_TAP: begin
            ctl.tap_en    = 1'b1;
            ctl.tap_first = (tap_k_ff == '0);
            tap_k_in      = tap_k_ff + 1'b1;
            if (tap_k_ff == HIST_IDX_W'(HIST_DEPTH - 1)) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            ctl.mul_en  = 1'b1;
            ctl.mul_sel = MS_RECIP;
            state_in    = ST_IERR;
         end
         ST_IERR: begin
            ctl.mul_en  = 1'b1;
            ctl.mul_sel = MS_IERR;
            ctl.acc_der = 1'b1;
            state_in    = ST_DSEC;
         end
         ST_DSEC: begin
            ctl.mul_en  = 1'b1;
            ctl.mul_sel = MS_DSEC;
            ctl.acc_add = 1'b1;
            state_in    = ST_INNER;
         end
         ST_INNER: begin
            ctl.acc_sub = 1'b1;
            state_in    = ST_PLO;
         end
         ST_PLO: begin
            ctl.mul_en  = 1'b1;
            ctl.mul_sel = MS_PLO;
            state_in    = ST_PHI;
         end
         ST_PHI: begin
            ctl.mul_en  = 1'b1;
            ctl.mul_sel = MS_PHI;
            ctl.tot_lo  = 1'b1;
            state_in    = ST_ADD;
         end
         ST_ADD: begin
            ctl.tot_hi = 1'b1;
            state_in   = ST_SAT;
         end
         ST_SAT: begin
            if (out_free) begin
               ctl.sat  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               ctl.hold = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
